@@ hw/rtl/vqs_pkg.sv @@
// Shared widths, types and register codes for the VQS point transform.
// No dependencies; imported by vqs_rot_matrix and vqs_point_transform_unit.
`default_nettype none
package vqs_pkg;

    // field widths
    localparam int COORD_W = 32;            // Q16.16 coordinate
    localparam int QUAT_W  = 16;            // Q1.14 quaternion part
    localparam int SCALE_W = 16;            // unsigned Q4.12 scale
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // internal widths
    localparam int QPROD_W = 2 * QUAT_W;        // quaternion part products, Q28
    localparam int M28_W   = QPROD_W + 2;       // matrix entry before rounding
    localparam int COEF_W  = 24;                // matrix entry, Q18
    localparam int PRAW_W  = COORD_W + SCALE_W + 1;  // scale * coordinate
    localparam int PT_W    = PRAW_W - 12;       // scaled point, Q16.16 wide
    localparam int MP_W    = COEF_W + PT_W;     // coefficient * point, Q34
    localparam int ACC_W   = MP_W + 2;          // row sum
    localparam int ROW_W   = ACC_W - 18;        // row sum back in Q16.16
    localparam int SUM_W   = ROW_W + 1;         // row plus translation

    localparam logic signed [M28_W-1:0] ONE_Q28 = M28_W'(64'sd268435456);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TRANSLATE_X = 3'd0,
        REG_TRANSLATE_Y = 3'd1,
        REG_TRANSLATE_Z = 3'd2,
        REG_ROT_X       = 3'd3,
        REG_ROT_Y       = 3'd4,
        REG_ROT_Z       = 3'd5,
        REG_ROT_S       = 3'd6,
        REG_SCALE       = 3'd7
    } t_reg_idx;

    typedef logic [COEF_W-1:0] t_coef;
    typedef t_coef [2:0][2:0] t_mat;        // [row][column]

    // Round half up from Q28 to Q18: floor((a + 2^9) / 2^10).
    function automatic t_coef round_coef(input logic signed [M28_W-1:0] a);
        logic signed [M28_W-1:0] t;
        t = a + M28_W'(64'sd512);
        return t[M28_W-1:10];
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/vqs_rot_matrix.sv @@
// Builds the 3x3 rotation matrix (Q18) from the quaternion registers.
// Two register stages: part products, then entries. Uses vqs_pkg.
`default_nettype none
module vqs_rot_matrix (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic signed [vqs_pkg::QUAT_W-1:0] i_rot_x,
    input  wire logic signed [vqs_pkg::QUAT_W-1:0] i_rot_y,
    input  wire logic signed [vqs_pkg::QUAT_W-1:0] i_rot_z,
    input  wire logic signed [vqs_pkg::QUAT_W-1:0] i_rot_s,
    output vqs_pkg::t_mat                          o_mat
);
    import vqs_pkg::*;

    localparam t_coef COEF_ONE  = COEF_W'(32'd262144);   // 1.0 in Q18
    localparam t_coef COEF_ZERO = '0;
    localparam t_mat  MAT_IDENTITY = {COEF_ONE,  COEF_ZERO, COEF_ZERO,
                                      COEF_ZERO, COEF_ONE,  COEF_ZERO,
                                      COEF_ZERO, COEF_ZERO, COEF_ONE};

    logic signed [QPROD_W-1:0] r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_sx, r_sy, r_sz;
    t_mat r_mat;
    t_mat n_mat;

    // stage A: products of quaternion parts (exact, Q28)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // reset quaternion is identity: every product used here is zero
            r_xx <= '0; r_yy <= '0; r_zz <= '0;
            r_xy <= '0; r_xz <= '0; r_yz <= '0;
            r_sx <= '0; r_sy <= '0; r_sz <= '0;
        end else begin
            r_xx <= i_rot_x * i_rot_x;
            r_yy <= i_rot_y * i_rot_y;
            r_zz <= i_rot_z * i_rot_z;
            r_xy <= i_rot_x * i_rot_y;
            r_xz <= i_rot_x * i_rot_z;
            r_yz <= i_rot_y * i_rot_z;
            r_sx <= i_rot_s * i_rot_x;
            r_sy <= i_rot_s * i_rot_y;
            r_sz <= i_rot_s * i_rot_z;
        end
    end

    // stage B: entries in Q28, rounded to Q18
    always_comb begin
        n_mat[0][0] = round_coef(ONE_Q28 - ((M28_W'(r_yy) + M28_W'(r_zz)) <<< 1));
        n_mat[0][1] = round_coef((M28_W'(r_xy) - M28_W'(r_sz)) <<< 1);
        n_mat[0][2] = round_coef((M28_W'(r_xz) + M28_W'(r_sy)) <<< 1);
        n_mat[1][0] = round_coef((M28_W'(r_xy) + M28_W'(r_sz)) <<< 1);
        n_mat[1][1] = round_coef(ONE_Q28 - ((M28_W'(r_xx) + M28_W'(r_zz)) <<< 1));
        n_mat[1][2] = round_coef((M28_W'(r_yz) - M28_W'(r_sx)) <<< 1);
        n_mat[2][0] = round_coef((M28_W'(r_xz) - M28_W'(r_sy)) <<< 1);
        n_mat[2][1] = round_coef((M28_W'(r_yz) + M28_W'(r_sx)) <<< 1);
        n_mat[2][2] = round_coef(ONE_Q28 - ((M28_W'(r_xx) + M28_W'(r_yy)) <<< 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat <= MAT_IDENTITY;
        end else begin
            r_mat <= n_mat;
        end
    end

    assign o_mat = r_mat;

endmodule
`default_nettype wire

@@ hw/rtl/vqs_point_transform_unit.sv @@
// Top level of the VQS point transform: config registers and point pipeline.
// Depends on vqs_pkg and vqs_rot_matrix.
`default_nettype none
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  ---------------------------------
//  point in  in         i_valid / o_stall         i_vertex_x/y/z (Q16.16)
//  point out out        o_valid / i_stall         o_out_x/y/z (Q16.16), o_saturated
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  One point per cycle sustained while i_stall is low; each point passes five
//  register stages: scale multiply, round, nine coefficient multiplies, row
//  sums, translate and clamp. o_valid is the valid bit of stage 5. The coefficient
//  multiplier stage sets the clock.
//  Reset (synchronous, low) loads the identity transform and empties the pipe.
//  Each stage keeps its transaction while the next one is full and cannot
//  move on, so a stall at the output holds the full stages and squeezes
//  out bubbles. A quaternion write reaches the matrix via both vqs_rot_matrix stages.
module vqs_point_transform_unit (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // config write
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [vqs_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [vqs_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    // points in
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic signed [vqs_pkg::COORD_W-1:0]    i_vertex_x,
    input  wire logic signed [vqs_pkg::COORD_W-1:0]    i_vertex_y,
    input  wire logic signed [vqs_pkg::COORD_W-1:0]    i_vertex_z,
    // points out
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic signed [vqs_pkg::COORD_W-1:0]         o_out_x,
    output logic signed [vqs_pkg::COORD_W-1:0]         o_out_y,
    output logic signed [vqs_pkg::COORD_W-1:0]         o_out_z,
    output logic                                       o_saturated
);
    import vqs_pkg::*;

    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(-64'sd2147483648);

    // ---------------- configuration registers ----------------
    logic signed [COORD_W-1:0] r_trans [3];
    logic signed [QUAT_W-1:0]  r_rot_x, r_rot_y, r_rot_z, r_rot_s;
    logic [SCALE_W-1:0]        r_scale;
    t_mat                      mat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trans[0] <= '0;
            r_trans[1] <= '0;
            r_trans[2] <= '0;
            r_rot_x    <= '0;
            r_rot_y    <= '0;
            r_rot_z    <= '0;
            r_rot_s    <= QUAT_W'(16'sd16384);   // 1.0
            r_scale    <= SCALE_W'(16'd4096);    // 1.0
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_TRANSLATE_X: r_trans[0] <= i_cfg_data;
                REG_TRANSLATE_Y: r_trans[1] <= i_cfg_data;
                REG_TRANSLATE_Z: r_trans[2] <= i_cfg_data;
                REG_ROT_X:       r_rot_x    <= i_cfg_data[QUAT_W-1:0];
                REG_ROT_Y:       r_rot_y    <= i_cfg_data[QUAT_W-1:0];
                REG_ROT_Z:       r_rot_z    <= i_cfg_data[QUAT_W-1:0];
                REG_ROT_S:       r_rot_s    <= i_cfg_data[QUAT_W-1:0];
                REG_SCALE:       r_scale    <= i_cfg_data[SCALE_W-1:0];
            endcase
        end
    end

    vqs_rot_matrix u_rot_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rot_x (r_rot_x),
        .i_rot_y (r_rot_y),
        .i_rot_z (r_rot_z),
        .i_rot_s (r_rot_s),
        .o_mat   (mat)
    );

    // ---------------- point pipeline ----------------
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    logic signed [PRAW_W-1:0] r_praw [3];     // stage 1: scale * coordinate
    logic signed [PT_W-1:0]   r_pt   [3];     // stage 2: scaled point
    logic signed [MP_W-1:0]   r_mp   [3][3];  // stage 3: coefficient products
    logic signed [ROW_W-1:0]  r_row  [3];     // stage 4: rounded row sums
    logic signed [COORD_W-1:0] r_out [3];     // stage 5: result
    logic                      r_sat;

    logic signed [COORD_W-1:0] vin    [3];
    logic signed [PRAW_W-1:0]  n_praw [3];
    logic signed [PT_W-1:0]    n_pt   [3];
    logic signed [MP_W-1:0]    n_mp   [3][3];
    logic signed [ROW_W-1:0]   n_row  [3];
    logic signed [COORD_W-1:0] n_out  [3];
    logic                      n_sat;

    // a stage loads when it is empty or its transaction moves on
    assign rdy5 = !r_v5 || !i_stall;
    assign rdy4 = !r_v4 || rdy5;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign o_stall = !rdy1;

    assign vin[0] = i_vertex_x;
    assign vin[1] = i_vertex_y;
    assign vin[2] = i_vertex_z;

    always_comb begin
        logic signed [PRAW_W-1:0] t_p;
        logic signed [ACC_W-1:0]  acc;
        logic signed [SUM_W-1:0]  s;
        n_sat = 1'b0;
        for (int r = 0; r < 3; r++) begin
            n_praw[r] = $signed({1'b0, r_scale}) * vin[r];
            // round half up by 2^12; arithmetic shift is floor
            t_p       = r_praw[r] + PRAW_W'(64'sd2048);
            n_pt[r]   = t_p[PRAW_W-1:12];
            for (int c = 0; c < 3; c++) begin
                n_mp[r][c] = $signed(mat[r][c]) * r_pt[c];
            end
            acc = ACC_W'(r_mp[r][0]) + ACC_W'(r_mp[r][1]) + ACC_W'(r_mp[r][2])
                + ACC_W'(64'sd131072);
            n_row[r] = acc[ACC_W-1:18];
            s = SUM_W'(r_row[r]) + SUM_W'(r_trans[r]);
            if (s > SAT_MAX) begin
                n_out[r] = SAT_MAX[COORD_W-1:0];
                n_sat    = 1'b1;
            end else if (s < SAT_MIN) begin
                n_out[r] = SAT_MIN[COORD_W-1:0];
                n_sat    = 1'b1;
            end else begin
                n_out[r] = s[COORD_W-1:0];
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            if (rdy5) r_v5 <= r_v4;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (rdy1) r_praw <= n_praw;
        if (rdy2) r_pt   <= n_pt;
        if (rdy3) r_mp   <= n_mp;
        if (rdy4) r_row  <= n_row;
        if (rdy5) begin
            r_out <= n_out;
            r_sat <= n_sat;
        end
    end

    assign o_valid     = r_v5;
    assign o_out_x     = r_out[0];
    assign o_out_y     = r_out[1];
    assign o_out_z     = r_out[2];
    assign o_saturated = r_sat;

    // ---------------- assertions ----------------
    // upstream stall only when every stage holds a transaction and output is held
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2 && r_v3 && r_v4 && r_v5 && i_stall))
        else $error("input stalled with room in the pipeline");

    // an accepted point occupies stage 1 next cycle
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_v1)
        else $error("accepted point lost at pipeline entry");

    // saturation flag implies some coordinate sits at a rail
    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            (o_out_x == SAT_MAX[COORD_W-1:0] || o_out_x == SAT_MIN[COORD_W-1:0] ||
             o_out_y == SAT_MAX[COORD_W-1:0] || o_out_y == SAT_MIN[COORD_W-1:0] ||
             o_out_z == SAT_MAX[COORD_W-1:0] || o_out_z == SAT_MIN[COORD_W-1:0]))
        else $error("saturated flag without a clamped coordinate");

endmodule
`default_nettype wire
